### rtl/core/surface_conflict_vote_core_defines.svh
// Assertion macros for the surface conflict vote core.
// Included by the top level; no other dependencies.
`ifndef SURFACE_CONFLICT_VOTE_CORE_DEFINES_SVH
`define SURFACE_CONFLICT_VOTE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SCV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scv: same-cycle check failed");
`define SCV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scv: next-cycle check failed");
`else
`define SCV_ASSERT_IMP(lbl, ante, cons)
`define SCV_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/core/scv_pkg.sv
// Shared types and constants of the surface conflict vote core.
// No dependencies; used by the controller, the datapath and the top level.
package scv_pkg;

    localparam int MAX_POINTS_DEF     = 65536;
    localparam int DIST_FRAC_BITS_DEF = 10;

    localparam int SUM_W       = 34;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int DIV_STEPS   = 16;
    localparam int SQ_STEPS    = 17;
    localparam int N_PROD      = 6;
    localparam int CNT_W       = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_W     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ERR_LIM   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REJ_PTS   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REJ_FRAC  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACC_PTS   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACC_FRAC  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAT_W     = 3'd7;

    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_CN = 3'd0;
    localparam t_mul_sel MUL_RW = 3'd1;
    localparam t_mul_sel MUL_FR = 3'd2;
    localparam t_mul_sel MUL_MN = 3'd3;
    localparam t_mul_sel MUL_AW = 3'd4;
    localparam t_mul_sel MUL_FA = 3'd5;
    localparam t_mul_sel MUL_AB = 3'd6;

    typedef struct packed {
        logic     capture;
        logic     prep;
        logic     classify;
        logic     load_a;
        logic     load_b;
        logic     div_step;
        logic     sqrt_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc;
        logic     out_load;
        logic     clear;
        logic     set_decided;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic mode;
        logic decided;
        logic last;
        logic res_valid;
        logic out_free;
    } t_stat;

endpackage

### rtl/core/scv_ctrl.sv
// Sequencing controller of the surface conflict vote core.
// Depends on scv_pkg; drives the datapath through command and status structs.
module scv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  scv_pkg::t_stat i_stat,
    output scv_pkg::t_cmd  o_cmd
);
    import scv_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_SKIP = 4'd2;
    localparam logic [3:0] ST_CLS  = 4'd3;
    localparam logic [3:0] ST_DIVA = 4'd4;
    localparam logic [3:0] ST_LDB  = 4'd5;
    localparam logic [3:0] ST_DIVB = 4'd6;
    localparam logic [3:0] ST_MUL  = 4'd7;
    localparam logic [3:0] ST_SQRT = 4'd8;
    localparam logic [3:0] ST_ACC  = 4'd9;
    localparam logic [3:0] ST_PROD = 4'd10;
    localparam logic [3:0] ST_DEC  = 4'd11;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = i_stat.decided ? ST_SKIP : ST_CLS;
            end
            ST_SKIP: begin
                o_cmd.clear = i_stat.last;
                n_state = ST_IDLE;
            end
            ST_CLS: begin
                o_cmd.classify = 1'b1;
                n_cnt = '0;
                if (i_stat.valid && i_stat.mode) begin
                    o_cmd.load_a = 1'b1;
                    n_state = ST_DIVA;
                end else begin
                    n_state = ST_ACC;
                end
            end
            ST_DIVA: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt = '0;
                    n_state = ST_LDB;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_LDB: begin
                o_cmd.load_b = 1'b1;
                n_state = ST_DIVB;
            end
            ST_DIVB: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt = '0;
                    n_state = ST_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_AB;
                n_cnt = '0;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                    n_cnt = '0;
                    n_state = ST_ACC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_cnt = '0;
                n_state = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = r_cnt[2:0];
                if (r_cnt == CNT_W'(N_PROD - 1)) begin
                    n_cnt = '0;
                    n_state = ST_DEC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DEC: begin
                if (i_stat.res_valid) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load    = 1'b1;
                        o_cmd.clear       = i_stat.last;
                        o_cmd.set_decided = !i_stat.last;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### rtl/core/scv_dp.sv
// Datapath of the surface conflict vote core: configuration, sums, shared
// divider, root unit and multiplier, and the result register. Depends on scv_pkg.
module scv_dp #(
    parameter int MAX_POINTS     = scv_pkg::MAX_POINTS_DEF,
    parameter int DIST_FRAC_BITS = scv_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [scv_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [scv_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic [23:0]                     i_point_weight,
    input  logic                            i_voxel_found,
    input  logic signed [15:0]              i_voxel_distance,
    input  logic [23:0]                     i_voxel_weight,
    input  logic                            i_class_present,
    input  logic                            i_belongs_flag,
    input  logic                            i_other_free_space,
    input  logic [14:0]                     i_other_voxel_size,
    input  logic [14:0]                     i_other_truncation,
    input  logic [16:0]                     i_point_count,
    input  logic                            i_last,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic                            o_conflict,
    output logic                            o_match,
    output logic                            o_early,
    input  scv_pkg::t_cmd                   i_cmd,
    output scv_pkg::t_stat                  o_stat
);
    import scv_pkg::*;

    localparam int F  = DIST_FRAC_BITS;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int MB = (NW > 17) ? NW : 17;
    localparam int PW = SUM_W + MB;
    localparam int TW = (15 + F > 31) ? 15 + F : 31;
    localparam int CW = (((17 + F) > (TW + 1)) ? (17 + F) : (TW + 1)) + 1;

    logic        r_mode;
    logic [23:0] r_min_w;
    logic [15:0] r_err_lim;
    logic [15:0] r_rej_pts;
    logic [16:0] r_rej_frac;
    logic [15:0] r_acc_pts;
    logic [16:0] r_acc_frac;
    logic [23:0] r_sat_w;

    logic [23:0] r_pw, r_vw;
    logic        r_found, r_cls, r_belongs, r_freesp, r_last;
    logic [15:0] r_dist;
    logic [14:0] r_vsize, r_trunc;
    logic [16:0] r_n_raw;

    logic [MB-1:0]    r_n;
    logic [TW-1:0]    r_thr;
    logic [23:0]      r_s;
    logic             r_valid;
    logic             r_is_conf, r_is_match;
    logic [23:0]      r_rem;
    logic [15:0]      r_q;
    logic [16:0]      r_a;
    logic [SUM_W-1:0] r_sq_v, r_sq_res, r_sq_bit;
    logic [SUM_W-1:0] r_cs, r_ms, r_ws;
    logic             r_decided;
    logic [PW-1:0]    r_prod [N_PROD];
    logic             r_out_valid, r_conflict, r_match, r_early;

    logic [31:0]      n_ext, n_clamp;
    logic [15:0]      neg_el;
    logic [30:0]      thr_mul;
    logic [TW-1:0]    thr_val;
    logic signed [16:0]   dsel;
    logic signed [CW-1:0] d_val, thr_s;
    logic [24:0]      div_r2;
    logic             div_ge;
    logic [16:0]      b_val;
    logic [SUM_W-1:0] sq_rb;
    logic             sq_ge;
    logic [SUM_W-1:0] mul_a;
    logic [MB-1:0]    mul_b;
    logic [PW-1:0]    mul_p;
    logic [SUM_W-1:0] vote_w;
    logic [SUM_W:0]   cs_add, ms_add, ws_add;
    logic [PW-1:0]    cs_sh, ms_sh;
    logic             early_hit, c1, m1, m0;

    // Point count clamp and distance threshold.
    always_comb begin
        n_ext   = 32'(r_n_raw);
        n_clamp = n_ext;
        if (n_ext == 32'd0) begin
            n_clamp = 32'd1;
        end else if (n_ext > 32'(MAX_POINTS)) begin
            n_clamp = 32'(MAX_POINTS);
        end
        neg_el  = 16'(-$signed(r_err_lim));
        thr_mul = 31'(neg_el) * 31'(r_vsize);
        if ($signed(r_err_lim) > 16'sd0) begin
            thr_val = TW'(r_err_lim[14:0]) << F;
        end else begin
            thr_val = TW'(thr_mul);
        end
    end

    always_comb begin
        if (!r_freesp && r_cls && !r_belongs) begin
            dsel = $signed({2'b00, r_trunc});
        end else begin
            dsel = $signed({r_dist[15], r_dist});
        end
        d_val = CW'(dsel) <<< F;
        thr_s = $signed({{(CW - TW){1'b0}}, r_thr});
    end

    assign div_r2 = {r_rem, 1'b0};
    assign div_ge = (div_r2 >= {1'b0, r_s});
    assign b_val  = (r_pw >= r_s) ? 17'd65536 : {1'b0, r_q};
    assign sq_rb  = r_sq_res + r_sq_bit;
    assign sq_ge  = (r_sq_v >= sq_rb);

    always_comb begin
        mul_a = r_cs;
        mul_b = r_n;
        unique case (i_cmd.mul_sel)
            MUL_CN: begin mul_a = r_cs; mul_b = r_n; end
            MUL_RW: begin mul_a = r_ws; mul_b = MB'(r_rej_pts); end
            MUL_FR: begin
                mul_a = r_mode ? r_ws : SUM_W'(r_n);
                mul_b = MB'(r_rej_frac);
            end
            MUL_MN: begin mul_a = r_ms; mul_b = r_n; end
            MUL_AW: begin mul_a = r_ws; mul_b = MB'(r_acc_pts); end
            MUL_FA: begin
                mul_a = r_mode ? r_ws : SUM_W'(r_n);
                mul_b = MB'(r_acc_frac);
            end
            MUL_AB: begin mul_a = SUM_W'(r_a); mul_b = MB'(b_val); end
            default: begin mul_a = r_cs; mul_b = r_n; end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    assign vote_w = r_mode ? r_sq_res : SUM_W'(1);
    assign cs_add = {1'b0, r_cs} + {1'b0, vote_w};
    assign ms_add = {1'b0, r_ms} + {1'b0, vote_w};
    assign ws_add = {1'b0, r_ws} + {1'b0, vote_w};

    // Verdict terms from the sums and the stored products.
    always_comb begin
        cs_sh = PW'(r_cs) << 16;
        ms_sh = PW'(r_ms) << 16;
        early_hit = !r_mode && r_valid && (r_cs > SUM_W'(r_rej_pts))
                    && (cs_sh > r_prod[MUL_FR]);
        c1 = (r_prod[MUL_CN] > r_prod[MUL_RW]) && (cs_sh > r_prod[MUL_FR]);
        m1 = (r_prod[MUL_MN] > r_prod[MUL_AW]) && (ms_sh > r_prod[MUL_FA]);
        m0 = (r_ms > SUM_W'(r_acc_pts)) && (ms_sh > r_prod[MUL_FA]);
    end

    assign o_stat.valid     = r_valid;
    assign o_stat.mode      = r_mode;
    assign o_stat.decided   = r_decided;
    assign o_stat.last      = r_last;
    assign o_stat.res_valid = early_hit || r_last;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_conflict  = r_conflict;
    assign o_match     = r_match;
    assign o_early     = r_early;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_min_w    <= '0;
            r_err_lim  <= 16'hF800;
            r_rej_pts  <= '0;
            r_rej_frac <= '0;
            r_acc_pts  <= '0;
            r_acc_frac <= '0;
            r_sat_w    <= 24'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MODE:     r_mode     <= i_cfg_wdata[0];
                CFG_MIN_W:    r_min_w    <= i_cfg_wdata[23:0];
                CFG_ERR_LIM:  r_err_lim  <= i_cfg_wdata[15:0];
                CFG_REJ_PTS:  r_rej_pts  <= i_cfg_wdata[15:0];
                CFG_REJ_FRAC: r_rej_frac <= i_cfg_wdata[16:0];
                CFG_ACC_PTS:  r_acc_pts  <= i_cfg_wdata[15:0];
                CFG_ACC_FRAC: r_acc_frac <= i_cfg_wdata[16:0];
                CFG_SAT_W:    r_sat_w    <= i_cfg_wdata[23:0];
                default:      r_mode     <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pw      <= i_point_weight;
            r_found   <= i_voxel_found;
            r_dist    <= i_voxel_distance;
            r_vw      <= i_voxel_weight;
            r_cls     <= i_class_present;
            r_belongs <= i_belongs_flag;
            r_freesp  <= i_other_free_space;
            r_vsize   <= i_other_voxel_size;
            r_trunc   <= i_other_truncation;
            r_n_raw   <= i_point_count;
            r_last    <= i_last;
        end
        if (i_cmd.prep) begin
            r_n     <= MB'(n_clamp);
            r_thr   <= thr_val;
            r_s     <= (r_sat_w == 24'd0) ? 24'd1 : r_sat_w;
            r_valid <= (r_pw >= r_min_w) && r_found && (r_vw >= r_min_w);
        end
        if (i_cmd.classify) begin
            if (r_freesp) begin
                r_is_conf  <= (d_val >= thr_s);
                r_is_match <= 1'b0;
            end else begin
                r_is_conf  <= (d_val <= -thr_s);
                r_is_match <= (d_val > -thr_s) && (d_val <= thr_s);
            end
        end
        if (i_cmd.load_a) begin
            r_rem <= r_vw;
        end else if (i_cmd.load_b) begin
            r_rem <= r_pw;
            r_a   <= (r_vw >= r_s) ? 17'd65536 : {1'b0, r_q};
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? 24'(div_r2 - {1'b0, r_s}) : div_r2[23:0];
            r_q   <= {r_q[14:0], div_ge};
        end
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_sel == MUL_AB) begin
                r_sq_v   <= SUM_W'(mul_p);
                r_sq_res <= '0;
                r_sq_bit <= SUM_W'(1) << 32;
            end else begin
                r_prod[i_cmd.mul_sel] <= mul_p;
            end
        end else if (i_cmd.sqrt_step) begin
            if (sq_ge) begin
                r_sq_v   <= r_sq_v - sq_rb;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs      <= '0;
            r_ms      <= '0;
            r_ws      <= '0;
            r_decided <= 1'b0;
        end else if (i_cmd.clear) begin
            r_cs      <= '0;
            r_ms      <= '0;
            r_ws      <= '0;
            r_decided <= 1'b0;
        end else begin
            if (i_cmd.set_decided) begin
                r_decided <= 1'b1;
            end
            if (i_cmd.acc && r_valid) begin
                if (r_mode) begin
                    r_ws <= ws_add[SUM_W] ? '1 : ws_add[SUM_W-1:0];
                end
                if (r_is_conf) begin
                    r_cs <= cs_add[SUM_W] ? '1 : cs_add[SUM_W-1:0];
                end else if (r_is_match) begin
                    r_ms <= ms_add[SUM_W] ? '1 : ms_add[SUM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_conflict <= early_hit || (r_mode && c1);
            r_match    <= !early_hit && (r_mode ? (!c1 && m1) : m0);
            r_early    <= early_hit && !r_last;
        end
    end

endmodule

### rtl/core/surface_conflict_vote_core.sv
// Top level of the surface conflict vote core: controller and datapath.
// Depends on scv_pkg, scv_ctrl, scv_dp and the assertion macro header.
//
// One reference surface point is taken per transfer and the block holds off
// further transfers until the point is finished. A valid point in weighted
// mode goes through the two 16-step divisions and the 17-step square root of
// the shared iterative unit, followed by six passes of the shared multiplier
// for the verdict products. Points that arrive after an early decision skip
// the vote. A verdict waits in an output register; if that register is still
// full when the next verdict is ready, the block waits for it to be taken.
`include "surface_conflict_vote_core_defines.svh"
module surface_conflict_vote_core #(
    parameter int MAX_POINTS     = scv_pkg::MAX_POINTS_DEF,
    parameter int DIST_FRAC_BITS = scv_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [scv_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [scv_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [23:0]                     i_point_weight,
    input  logic                            i_voxel_found,
    input  logic signed [15:0]              i_voxel_distance,
    input  logic [23:0]                     i_voxel_weight,
    input  logic                            i_class_present,
    input  logic                            i_belongs_flag,
    input  logic                            i_other_free_space,
    input  logic [14:0]                     i_other_voxel_size,
    input  logic [14:0]                     i_other_truncation,
    input  logic [16:0]                     i_point_count,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_conflict,
    output logic                            o_match,
    output logic                            o_early
);
    import scv_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    scv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    scv_dp #(
        .MAX_POINTS     (MAX_POINTS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_point_weight     (i_point_weight),
        .i_voxel_found      (i_voxel_found),
        .i_voxel_distance   (i_voxel_distance),
        .i_voxel_weight     (i_voxel_weight),
        .i_class_present    (i_class_present),
        .i_belongs_flag     (i_belongs_flag),
        .i_other_free_space (i_other_free_space),
        .i_other_voxel_size (i_other_voxel_size),
        .i_other_truncation (i_other_truncation),
        .i_point_count      (i_point_count),
        .i_last             (i_last),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_conflict         (o_conflict),
        .o_match            (o_match),
        .o_early            (o_early),
        .i_cmd              (cmd),
        .o_stat             (stat)
    );

    `SCV_ASSERT_IMP(a_verdict_exclusive, o_out_valid, !(o_conflict && o_match))
    `SCV_ASSERT_IMP(a_early_is_conflict, o_out_valid && o_early, o_conflict)
    `SCV_ASSERT_NXT(a_one_point_at_a_time, i_in_valid && !o_in_stall, o_in_stall)

endmodule

### tb/tb_surface_conflict_vote_core.sv
// Self-checking testbench for the surface conflict vote core.
// Depends on scv_pkg and surface_conflict_vote_core; predicts verdicts per point.
`timescale 1ns / 1ps
module tb_surface_conflict_vote_core;
    import scv_pkg::*;

    localparam logic [33:0] SUM_SAT = 34'h3_FFFF_FFFF;

    typedef struct packed {
        logic [23:0] pw;
        logic        found;
        logic [15:0] vdist;
        logic [23:0] vw;
        logic        cls;
        logic        belongs;
        logic        freesp;
        logic [14:0] vsize;
        logic [14:0] trunc;
        logic [16:0] count;
        logic        last;
    } t_point;

    typedef struct packed {
        logic conflict;
        logic match;
        logic early;
    } t_verdict;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 0;
    logic i_out_stall = 0;
    t_point cur = '0;
    logic o_in_stall, o_out_valid, o_conflict, o_match, o_early;

    surface_conflict_vote_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_point_weight(cur.pw), .i_voxel_found(cur.found),
        .i_voxel_distance(cur.vdist), .i_voxel_weight(cur.vw),
        .i_class_present(cur.cls), .i_belongs_flag(cur.belongs),
        .i_other_free_space(cur.freesp), .i_other_voxel_size(cur.vsize),
        .i_other_truncation(cur.trunc), .i_point_count(cur.count), .i_last(cur.last),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_conflict(o_conflict), .o_match(o_match), .o_early(o_early)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Predictor state and register copy.
    logic        m_mode;
    logic [23:0] m_min_w;
    logic signed [15:0] m_err_lim;
    logic [15:0] m_rej_pts, m_acc_pts;
    logic [16:0] m_rej_frac, m_acc_frac;
    logic [23:0] m_sat_w;
    logic [33:0] conflict_total, match_total, weight_total;
    logic        run_decided;

    t_point   pending_points[$];
    t_verdict expected_verdicts[$];
    int  fail_count = 0;
    bit  hold_sender = 0;
    bit  in_taken = 0;

    function automatic logic [33:0] sum_sat(logic [33:0] a, logic [63:0] b);
        logic [63:0] s;
        s = {30'd0, a} + b;
        return (s > SUM_SAT) ? SUM_SAT : s[33:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, lo, hi, mid;
        lo = 0;
        hi = 64'h1_0000_0000;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        r = lo;
        return r;
    endfunction

    function automatic logic [63:0] confidence(logic [63:0] vw, logic [63:0] pw);
        logic [63:0] s, a, b;
        s = (m_sat_w == 0) ? 64'd1 : {40'd0, m_sat_w};
        if (vw == 0 || pw == 0) return 0;
        if (vw >= s && pw >= s) return 64'd65536;
        a = (vw >= s) ? 64'd65536 : (vw << 16) / s;
        b = (pw >= s) ? 64'd65536 : (pw << 16) / s;
        return int_sqrt(a * b);
    endfunction

    task automatic clear_run();
        conflict_total = 0;
        match_total = 0;
        weight_total = 0;
        run_decided = 0;
    endtask

    task automatic predict_vote(t_point p);
        logic [63:0] n, w, wt;
        longint thr, d;
        t_verdict v;
        n = 64'(p.count);
        if (n < 1) n = 1;
        if (n > 65536) n = 65536;
        if (run_decided) begin
            if (p.last) clear_run();
            return;
        end
        if (p.pw >= m_min_w && p.found && p.vw >= m_min_w) begin
            if (m_mode) begin
                w = confidence(64'(p.vw), 64'(p.pw));
                weight_total = sum_sat(weight_total, w);
            end else begin
                w = 1;
            end
            thr = (m_err_lim > 0) ? longint'(m_err_lim) * 1024
                                  : -longint'(m_err_lim) * longint'(p.vsize);
            d = longint'($signed(p.vdist));
            if (p.freesp) begin
                if (d * 1024 >= thr) conflict_total = sum_sat(conflict_total, w);
            end else begin
                if (p.cls && !p.belongs) d = longint'(p.trunc);
                d = d * 1024;
                if (d <= -thr) conflict_total = sum_sat(conflict_total, w);
                else if (d <= thr) match_total = sum_sat(match_total, w);
            end
            if (!m_mode && conflict_total > m_rej_pts &&
                {30'd0, conflict_total} * 65536 > {47'd0, m_rej_frac} * n) begin
                v = '{conflict: 1'b1, match: 1'b0, early: !p.last};
                expected_verdicts.push_back(v);
                if (p.last) clear_run();
                else run_decided = 1;
                return;
            end
        end
        if (p.last) begin
            v = '0;
            if (m_mode) begin
                wt = weight_total;
                if (conflict_total * n > m_rej_pts * wt &&
                    conflict_total * 64'd65536 > m_rej_frac * wt)
                    v.conflict = 1;
                else if (match_total * n > m_acc_pts * wt &&
                         match_total * 64'd65536 > m_acc_frac * wt)
                    v.match = 1;
            end else begin
                if (match_total > m_acc_pts &&
                    {30'd0, match_total} * 65536 > {47'd0, m_acc_frac} * n)
                    v.match = 1;
            end
            expected_verdicts.push_back(v);
            clear_run();
        end
    endtask

    // Input transfers are taken at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_vote(cur);
            void'(pending_points.pop_front());
            in_taken = 1;
        end
    end

    // Driver: one pending point per transfer, with a random gap after each one taken.
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_taken) begin
            end else begin
                if (in_taken) begin
                    in_taken = 0;
                    gap_left = $urandom_range(0, 10);
                    if ($urandom_range(0, 3) == 0) gap_left = 0;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 0;
                end else if (pending_points.size() > 0 && !hold_sender) begin
                    cur <= pending_points[0];
                    i_in_valid <= 1;
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // Receiver stall and result monitor.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= 0;
        end
    end

    always @(posedge i_clk) begin
        t_verdict e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            if (expected_verdicts.size() == 0) begin
                $error("unexpected verdict transfer");
                fail_count++;
            end else begin
                e = expected_verdicts.pop_front();
                if (o_conflict !== e.conflict) begin
                    $error("conflict: expected %0b actual %0b", e.conflict, o_conflict);
                    fail_count++;
                end
                if (o_match !== e.match) begin
                    $error("match: expected %0b actual %0b", e.match, o_match);
                    fail_count++;
                end
                if (o_early !== e.early) begin
                    $error("early: expected %0b actual %0b", e.early, o_early);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_MODE:     m_mode = val[0];
            CFG_MIN_W:    m_min_w = val;
            CFG_ERR_LIM:  m_err_lim = val[15:0];
            CFG_REJ_PTS:  m_rej_pts = val[15:0];
            CFG_REJ_FRAC: m_rej_frac = val[16:0];
            CFG_ACC_PTS:  m_acc_pts = val[15:0];
            CFG_ACC_FRAC: m_acc_frac = val[16:0];
            CFG_SAT_W:    m_sat_w = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_points.size() > 0 || i_in_valid || expected_verdicts.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_point rand_point(logic [16:0] n, logic lst, bit plausible);
        t_point p;
        p.pw = plausible ? 24'($urandom_range(0, 1024)) : 24'($urandom);
        p.found = plausible ? ($urandom_range(0, 7) != 0) : 1'($urandom);
        p.vdist = plausible ? 16'($urandom_range(0, 8192) - 4096) : 16'($urandom);
        p.vw = plausible ? 24'($urandom_range(0, 1024)) : 24'($urandom);
        p.cls = 1'($urandom);
        p.belongs = 1'($urandom);
        p.freesp = ($urandom_range(0, 3) == 0);
        p.vsize = plausible ? 15'($urandom_range(1, 1024)) : 15'($urandom_range(1, 32767));
        p.trunc = 15'($urandom);
        p.count = n;
        p.last = lst;
        return p;
    endfunction

    task automatic queue_run(int len, logic [16:0] n);
        for (int k = 0; k < len; k++)
            pending_points.push_back(rand_point(n, k == len - 1, $urandom_range(0, 9) != 0));
    endtask

    task automatic random_setting(bit mode);
        write_reg(CFG_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_MIN_W, CFG_DATA_W'($urandom_range(0, 3) == 0 ?
                                         $urandom_range(0, 512) : 0));
        write_reg(CFG_ERR_LIM, CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 4096)
                                           : 16'(-$urandom_range(0, 4))));
        write_reg(CFG_REJ_PTS, CFG_DATA_W'($urandom_range(0, 6)));
        write_reg(CFG_REJ_FRAC, CFG_DATA_W'($urandom_range(0, 65536)));
        write_reg(CFG_ACC_PTS, CFG_DATA_W'($urandom_range(0, 6)));
        write_reg(CFG_ACC_FRAC, CFG_DATA_W'($urandom_range(0, 65536)));
        write_reg(CFG_SAT_W, CFG_DATA_W'($urandom_range(1, 1024)));
    endtask

    initial begin
        t_point p;
        m_mode = 0; m_min_w = 0; m_err_lim = -16'sd2048;
        m_rej_pts = 0; m_rej_frac = 0; m_acc_pts = 0; m_acc_frac = 0; m_sat_w = 256;
        clear_run();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed part at reset settings: extremes, free space, class override.
        p = '{pw: 24'hFFFFFF, found: 1, vdist: 16'h7FFF, vw: 24'hFFFFFF, cls: 0,
              belongs: 0, freesp: 1, vsize: 15'h7FFF, trunc: 15'h7FFF,
              count: 17'h1FFFF, last: 0};
        pending_points.push_back(p);
        p.vdist = 16'h8000; p.freesp = 0; p.count = 0;
        pending_points.push_back(p);
        p.last = 1; p.vdist = 0; p.cls = 1; p.pw = 0; p.vw = 0; p.found = 0;
        pending_points.push_back(p);
        p = '{pw: 24'd300, found: 1, vdist: 16'd0, vw: 24'd100, cls: 1, belongs: 1,
              freesp: 0, vsize: 15'd1, trunc: 15'd0, count: 17'd4, last: 0};
        pending_points.push_back(p);
        p.cls = 1; p.belongs = 0; p.trunc = 15'd5000;
        pending_points.push_back(p);
        p.last = 1;
        pending_points.push_back(p);
        wait_idle();

        // Weighted mode, largest thresholds and saturation, then smallest ones.
        write_reg(CFG_MODE, CFG_DATA_W'(1));
        write_reg(CFG_MIN_W, 24'hFFFFFF);
        write_reg(CFG_ERR_LIM, CFG_DATA_W'(16'h7FFF));
        write_reg(CFG_REJ_PTS, CFG_DATA_W'(16'hFFFF));
        write_reg(CFG_REJ_FRAC, CFG_DATA_W'(17'h10000));
        write_reg(CFG_ACC_PTS, CFG_DATA_W'(16'hFFFF));
        write_reg(CFG_ACC_FRAC, CFG_DATA_W'(17'h10000));
        write_reg(CFG_SAT_W, 24'hFFFFFF);
        queue_run(4, 17'd4);
        p = '{pw: 24'hFFFFFF, found: 1, vdist: 16'd0, vw: 24'hFFFFFF, cls: 0,
              belongs: 0, freesp: 0, vsize: 15'd1, trunc: 15'd0, count: 17'd1, last: 1};
        pending_points.push_back(p);
        wait_idle();
        write_reg(CFG_MIN_W, CFG_DATA_W'(0));
        write_reg(CFG_REJ_PTS, CFG_DATA_W'(0));
        write_reg(CFG_REJ_FRAC, CFG_DATA_W'(0));
        write_reg(CFG_ACC_PTS, CFG_DATA_W'(0));
        write_reg(CFG_ACC_FRAC, CFG_DATA_W'(0));
        write_reg(CFG_SAT_W, CFG_DATA_W'(1));
        queue_run(5, 17'd5);
        wait_idle();

        // Random phases alternating between the two modes.
        for (int ph = 0; ph < 13; ph++) begin
            random_setting(ph[0]);
            for (int r = 0; r < 6; r++) begin
                int len;
                len = $urandom_range(1, 10);
                queue_run(len, 17'($urandom_range(0, 3) == 0 ? $urandom : len));
                if (ph == 5 && r == 2) begin
                    while (pending_points.size() > 0 || i_in_valid) @(posedge i_clk);
                    hold_sender = 1;
                    while (expected_verdicts.size() > 0) @(posedge i_clk);
                    hold_sender = 0;
                end
            end
            wait_idle();
        end
        if (fail_count == 0) $display("surface_conflict_vote_core test passed");
        else $display("surface_conflict_vote_core test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("surface_conflict_vote_core test failed");
        $finish;
    end
endmodule
